// ----- hdl/slbs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slbs_pkg: status LED blink sequencer shared definitions
// Request and mode codes, register indexes, state and color types.
// ----------------------------------------------------------------------------
package slbs_pkg;

  localparam int unsigned TIME_W     = 32;
  localparam int unsigned INTERVAL_W = 16;
  localparam int unsigned COUNT_W    = 8;
  localparam int unsigned LEVEL_W    = 8;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [1:0] {
    REQ_UPDATE   = 2'd0,
    REQ_SET_MODE = 2'd1,
    REQ_FLASH    = 2'd2
  } req_t;

  typedef enum logic [2:0] {
    MODE_BOOT        = 3'd0,
    MODE_WIFI_CONN   = 3'd1,
    MODE_WIFI_UP     = 3'd2,
    MODE_BROKER_CONN = 3'd3,
    MODE_ONLINE      = 3'd4,
    MODE_ALARM       = 3'd5,
    MODE_ERROR       = 3'd6,
    MODE_OFF         = 3'd7
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BOOT_INTERVAL    = 3'd0,
    CFG_CONNECT_INTERVAL = 3'd1,
    CFG_ALARM_INTERVAL   = 3'd2,
    CFG_ERROR_INTERVAL   = 3'd3,
    CFG_FLASH_INTERVAL   = 3'd4,
    CFG_FLASH_TOTAL      = 3'd5
  } cfg_idx_t;

  localparam logic [INTERVAL_W-1:0] BOOT_INTERVAL_RST    = 16'd100;
  localparam logic [INTERVAL_W-1:0] CONNECT_INTERVAL_RST = 16'd1000;
  localparam logic [INTERVAL_W-1:0] ALARM_INTERVAL_RST   = 16'd1000;
  localparam logic [INTERVAL_W-1:0] ERROR_INTERVAL_RST   = 16'd150;
  localparam logic [INTERVAL_W-1:0] FLASH_INTERVAL_RST   = 16'd75;
  localparam logic [COUNT_W-1:0]    FLASH_TOTAL_RST      = 8'd3;

  typedef struct packed {
    logic [INTERVAL_W-1:0] boot_interval;
    logic [INTERVAL_W-1:0] connect_interval;
    logic [INTERVAL_W-1:0] alarm_interval;
    logic [INTERVAL_W-1:0] error_interval;
    logic [INTERVAL_W-1:0] flash_interval;
    logic [COUNT_W-1:0]    flash_total;
  } cfg_t;

  typedef struct packed {
    mode_t              mode;
    logic [TIME_W-1:0]  blink_stamp;
    logic               blink_phase;
    logic               flash_busy;
    logic [TIME_W-1:0]  flash_stamp;
    logic               flash_phase;
    logic [COUNT_W-1:0] flash_done;
  } seq_state_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] red;
    logic [LEVEL_W-1:0] green;
    logic [LEVEL_W-1:0] blue;
  } color_t;

  localparam color_t COLOR_BLACK = '{red: 8'd0,   green: 8'd0,   blue: 8'd0};
  localparam color_t COLOR_GREEN = '{red: 8'd0,   green: 8'd255, blue: 8'd0};
  localparam color_t COLOR_BLUE  = '{red: 8'd0,   green: 8'd0,   blue: 8'd255};
  localparam color_t COLOR_RED   = '{red: 8'd255, green: 8'd0,   blue: 8'd0};
  localparam color_t COLOR_AMBER = '{red: 8'd255, green: 8'd180, blue: 8'd0};

  // lit color of each mode; blinking modes alternate with black
  function automatic color_t mode_color(input mode_t m);
    color_t c;
    unique case (m)
      MODE_BOOT:        c = COLOR_AMBER;
      MODE_WIFI_CONN:   c = COLOR_BLUE;
      MODE_WIFI_UP:     c = COLOR_BLUE;
      MODE_BROKER_CONN: c = COLOR_GREEN;
      MODE_ONLINE:      c = COLOR_GREEN;
      MODE_ALARM:       c = COLOR_RED;
      MODE_ERROR:       c = COLOR_RED;
      default:          c = COLOR_BLACK;
    endcase
    return c;
  endfunction

  function automatic logic mode_blinks(input mode_t m);
    logic b;
    unique case (m)
      MODE_BOOT, MODE_WIFI_CONN, MODE_BROKER_CONN,
      MODE_ALARM, MODE_ERROR: b = 1'b1;
      default:                b = 1'b0;
    endcase
    return b;
  endfunction

endpackage

// ----- hdl/slbs_step.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slbs_step: next-state and color logic for one transaction
// Pure combinational: decodes the request, updates blink and flash state
// and tells whether the LED gets written on this update.
// ----------------------------------------------------------------------------
module slbs_step
  import slbs_pkg::*;
(
  input  cfg_t               cfg,
  input  seq_state_t         st,
  input  logic [1:0]         req_type,
  input  logic [TIME_W-1:0]  now_ms,
  input  logic [2:0]         new_mode,
  output seq_state_t         st_next,
  output logic               emit,
  output color_t             color
);

  logic [INTERVAL_W-1:0] blink_interval;
  logic [TIME_W-1:0]     blink_elapsed;
  logic [TIME_W-1:0]     flash_elapsed;
  logic                  blink_due;
  logic                  flash_due;
  logic                  flash_active;
  logic [COUNT_W-1:0]    done_inc;

  always_comb begin
    unique case (st.mode)
      MODE_BOOT:               blink_interval = cfg.boot_interval;
      MODE_ALARM:              blink_interval = cfg.alarm_interval;
      MODE_ERROR:              blink_interval = cfg.error_interval;
      default:                 blink_interval = cfg.connect_interval;
    endcase
  end

  // elapsed time wraps modulo 2^32
  assign blink_elapsed = now_ms - st.blink_stamp;
  assign flash_elapsed = now_ms - st.flash_stamp;
  assign blink_due     = blink_elapsed >= {{(TIME_W-INTERVAL_W){1'b0}}, blink_interval};
  assign flash_due     = flash_elapsed >= {{(TIME_W-INTERVAL_W){1'b0}}, cfg.flash_interval};
  assign flash_active  = st.flash_busy && (st.mode != MODE_ALARM) && (st.mode != MODE_ERROR);
  assign done_inc      = st.flash_done + 1'b1;

  always_comb begin
    st_next = st;
    emit    = 1'b0;
    color   = COLOR_BLACK;
    case (req_type)
      REQ_SET_MODE: begin
        if (new_mode != st.mode) begin
          st_next.mode        = mode_t'(new_mode);
          st_next.blink_stamp = '0;
          st_next.blink_phase = 1'b0;
        end
      end
      REQ_FLASH: begin
        st_next.flash_busy  = 1'b1;
        st_next.flash_stamp = '0;
        st_next.flash_phase = 1'b0;
        st_next.flash_done  = '0;
      end
      REQ_UPDATE: begin
        if (flash_active) begin
          if (flash_due) begin
            emit                = 1'b1;
            st_next.flash_stamp = now_ms;
            st_next.flash_phase = ~st.flash_phase;
            if (!st.flash_phase) begin
              color = COLOR_GREEN;
            end else if (done_inc >= cfg.flash_total) begin
              // burst complete
              st_next.flash_busy  = 1'b0;
              st_next.flash_done  = '0;
              st_next.flash_phase = 1'b0;
            end else begin
              st_next.flash_done = done_inc;
            end
          end
        end else if (mode_blinks(st.mode)) begin
          if (blink_due) begin
            emit                = 1'b1;
            st_next.blink_stamp = now_ms;
            st_next.blink_phase = ~st.blink_phase;
            if (!st.blink_phase) begin
              color = mode_color(st.mode);
            end
          end
        end else begin
          emit  = 1'b1;
          color = mode_color(st.mode);
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- hdl/slbs_out_buf.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slbs_out_buf: two-entry result buffer
// Output register plus one skid entry, so input accept never waits on
// the downstream ready of the same cycle.
// ----------------------------------------------------------------------------
module slbs_out_buf
  import slbs_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  color_t push_color,
  output logic   space,
  output logic   out_valid,
  input  logic   out_ready,
  output color_t out_color
);

  logic   head_valid;
  color_t head_color;
  logic   skid_valid;
  color_t skid_color;
  logic   pop;

  assign pop       = head_valid && out_ready;
  assign space     = !skid_valid;
  assign out_valid = head_valid;
  assign out_color = head_color;

  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (head_valid && !pop) begin
      if (push) begin
        skid_valid <= 1'b1;
      end
    end else if (skid_valid) begin
      head_valid <= 1'b1;
      skid_valid <= 1'b0;
    end else begin
      head_valid <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (head_valid && !pop) begin
      if (push) begin
        skid_color <= push_color;
      end
    end else if (skid_valid) begin
      head_color <= skid_color;
    end else if (push) begin
      head_color <= push_color;
    end
  end

endmodule

// ----- hdl/status_led_blink_sequencer_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// status_led_blink_sequencer_core: RGB status LED sequencer
// Takes mode changes, flash triggers and millisecond updates and emits the
// LED color whenever the LED is written.
// ----------------------------------------------------------------------------
// One transaction is taken every clock cycle while in_ready is high. Mode
// and flash transactions only update internal state; an update transaction
// produces a color when the LED is due to change (or on every update in a
// steady mode), registered into the output register or, while that is
// occupied, the skid entry; in_ready only drops when two colors are waiting
// downstream. The user must write the configuration registers (cfg_wr_en/
// cfg_index/cfg_data) only while no transaction is in flight; not enforced.
// ----------------------------------------------------------------------------
module status_led_blink_sequencer_core
  import slbs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            req_type,
  input  logic [TIME_W-1:0]     now_ms,
  input  logic [2:0]            new_mode,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [LEVEL_W-1:0]    red_level,
  output logic [LEVEL_W-1:0]    green_level,
  output logic [LEVEL_W-1:0]    blue_level,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t       cfg;
  seq_state_t st;
  seq_state_t st_next;
  logic       emit;
  color_t     step_color;
  color_t     out_color;
  logic       accept;

  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.boot_interval    <= BOOT_INTERVAL_RST;
      cfg.connect_interval <= CONNECT_INTERVAL_RST;
      cfg.alarm_interval   <= ALARM_INTERVAL_RST;
      cfg.error_interval   <= ERROR_INTERVAL_RST;
      cfg.flash_interval   <= FLASH_INTERVAL_RST;
      cfg.flash_total      <= FLASH_TOTAL_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_BOOT_INTERVAL:    cfg.boot_interval    <= cfg_data;
        CFG_CONNECT_INTERVAL: cfg.connect_interval <= cfg_data;
        CFG_ALARM_INTERVAL:   cfg.alarm_interval   <= cfg_data;
        CFG_ERROR_INTERVAL:   cfg.error_interval   <= cfg_data;
        CFG_FLASH_INTERVAL:   cfg.flash_interval   <= cfg_data;
        CFG_FLASH_TOTAL:      cfg.flash_total      <= cfg_data[COUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st.mode        <= MODE_OFF;
      st.blink_stamp <= '0;
      st.blink_phase <= 1'b0;
      st.flash_busy  <= 1'b0;
      st.flash_stamp <= '0;
      st.flash_phase <= 1'b0;
      st.flash_done  <= '0;
    end else if (accept) begin
      st <= st_next;
    end
  end

  slbs_step u_step (
    .cfg      (cfg),
    .st       (st),
    .req_type (req_type),
    .now_ms   (now_ms),
    .new_mode (new_mode),
    .st_next  (st_next),
    .emit     (emit),
    .color    (step_color)
  );

  slbs_out_buf u_out_buf (
    .clk        (clk),
    .rst        (rst),
    .push       (accept && emit),
    .push_color (step_color),
    .space      (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_color  (out_color)
  );

  assign red_level   = out_color.red;
  assign green_level = out_color.green;
  assign blue_level  = out_color.blue;

endmodule

// ----- hdl/slbs_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slbs_checker: port-level checks for the status LED sequencer
// Watches handshakes and result buffering over time; bound to the top.
// ----------------------------------------------------------------------------
module slbs_checker
  import slbs_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic [1:0]           req_type,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [LEVEL_W-1:0]   red_level,
  input logic [LEVEL_W-1:0]   green_level,
  input logic [LEVEL_W-1:0]   blue_level
);

  // backpressure only when the output register is occupied
  assert property (@(posedge clk) disable iff (rst) !in_ready |-> out_valid)
    else $error("in_ready low with empty output");

  // a stalled color holds until taken
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(red_level)
      && $stable(green_level) && $stable(blue_level))
    else $error("stalled color changed");

  // draining a full buffer frees the skid entry and keeps a color up
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !in_ready |=> in_ready && out_valid)
    else $error("skid entry not moved to output");

  // non-update transactions never produce a color
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && req_type != REQ_UPDATE && !out_valid |=> !out_valid)
    else $error("color produced by non-update transaction");

endmodule

bind status_led_blink_sequencer_core slbs_checker u_slbs_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .req_type    (req_type),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .red_level   (red_level),
  .green_level (green_level),
  .blue_level  (blue_level)
);
